[hdl/ttgp_pkg.sv]
`timescale 1ns / 1ps
package ttgp_pkg;

   // Exon table depth and derived index/count widths
   localparam int MAX_EXONS  = 64;
   localparam int IDX_W      = $clog2(MAX_EXONS);
   localparam int CNT_W      = $clog2(MAX_EXONS + 1);

   // Field widths
   localparam int COORD_W    = 32;
   localparam int POS_W      = 24;
   localparam int TXC_W      = POS_W + 1;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_STRAND_MINUS = 1'b0;
   localparam logic REG_FLANK_LENGTH = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      REQ_CLEAR    = 2'd0,
      REQ_APPEND   = 2'd1,
      REQ_JUNCTION = 2'd2,
      REQ_QUERY    = 2'd3
   } req_code_type;

   typedef struct packed {
      logic             strand_minus;
      logic [POS_W-1:0] flank_length;
   } cfg_type;

   typedef struct packed {
      logic               sub;
      logic [COORD_W-1:0] a;
      logic [COORD_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] res;
      logic               ge;
   } alu_rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] ex_start;
      logic [COORD_W-1:0] ex_stop;
   } exon_type;

   typedef struct packed {
      logic [COORD_W-1:0] bstart;
      logic [POS_W-1:0]   blen;
   } blk_type;

endpackage

[hdl/ttgp_ram.sv]
`timescale 1ns / 1ps
module ttgp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[hdl/ttgp_alu.sv]
`timescale 1ns / 1ps
module ttgp_alu (
   input  ttgp_pkg::alu_req_type req,
   output ttgp_pkg::alu_rsp_type rsp
);
   import ttgp_pkg::*;

   logic [COORD_W:0] sum;

   // Add or subtract; carry out of a subtract means a >= b
   always_comb begin
      sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
          + {{COORD_W{1'b0}}, req.sub};
      rsp.res = sum[COORD_W-1:0];
      rsp.ge  = sum[COORD_W];
   end

endmodule

[hdl/ttgp_csr.sv]
`timescale 1ns / 1ps
module ttgp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ttgp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ttgp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ttgp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output ttgp_pkg::cfg_type                 cfg
);
   import ttgp_pkg::*;

   logic             strand_minus_ff;
   logic [POS_W-1:0] flank_length_ff;
   logic             reg_sel;
   logic             wr_en;

   assign reg_sel = paddr[CSR_ADDR_W-1];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   // Write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         strand_minus_ff <= 1'b0;
         flank_length_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_STRAND_MINUS: strand_minus_ff <= pwdata[0];
            REG_FLANK_LENGTH: flank_length_ff <= pwdata[POS_W-1:0];
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         REG_STRAND_MINUS: prdata = {{(CSR_DATA_W-1){1'b0}}, strand_minus_ff};
         REG_FLANK_LENGTH: prdata = {{(CSR_DATA_W-POS_W){1'b0}}, flank_length_ff};
      endcase
   end

   assign cfg.strand_minus = strand_minus_ff;
   assign cfg.flank_length = flank_length_ff;

endmodule

[hdl/transcript_to_genome_projection.sv]
`timescale 1ns / 1ps
// Transcript-to-genome projection over one loaded exon table.
// Request channel (req_*): one beat is clear, append exon, load junction or
// project query. Clear and append complete in the idle state; a junction load
// then steps through ST_JCT_RS and ST_JCT_WR. A query walks the exons in
// transcript order through one shared adder: each exon is read and its length
// and offset are compared; a skipped exon moves the position on, and a cut
// exon gets its available length, take, block start (one more subtract on the
// minus strand), remaining length and position, then is shifted into start
// order; each result is then read back and its end, intron and span reckoned.
// req_stall stays high for the whole query, until its last beat is taken.
// Result channel (rsp_*): blocks come in ascending genomic start order, the
// final one with rsp_last_block set. A failed query (zero length, empty or
// overflowed table, no overlap) gives one beat with rsp_result_valid low.
// A result is held in the output register while rsp_stall is high; emission
// waits for it. Register port: strand_minus at 0x0, flank_length at 0x4; the
// user must write them only while the block is idle; no check enforces it.
// Reset empties the table, clears overflow and both registers, and drops any
// result in flight.
module transcript_to_genome_projection (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [ttgp_pkg::COORD_W-1:0]      req_exon_start,
   input  logic [ttgp_pkg::COORD_W-1:0]      req_exon_end,
   input  logic [ttgp_pkg::COORD_W-1:0]      req_donor_site,
   input  logic [ttgp_pkg::COORD_W-1:0]      req_acceptor_site,
   input  logic [ttgp_pkg::POS_W-1:0]        req_tx_pos,
   input  logic [ttgp_pkg::POS_W-1:0]        req_align_len,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_result_valid,
   output logic [ttgp_pkg::COORD_W-1:0]      rsp_block_start,
   output logic [ttgp_pkg::POS_W-1:0]        rsp_block_length,
   output logic [ttgp_pkg::COORD_W-1:0]      rsp_intron_length,
   output logic [ttgp_pkg::COORD_W-1:0]      rsp_span_so_far,
   output logic                              rsp_last_block,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ttgp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ttgp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ttgp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import ttgp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_JCT_RS, ST_JCT_WR,
      ST_RD, ST_LEN, ST_OFF, ST_CMP, ST_SKIP, ST_AVL, ST_TAKE,
      ST_BS1, ST_BS2, ST_REM, ST_POS,
      ST_INS, ST_INS_CMP, ST_INS_WR,
      ST_EM_RD, ST_EM_END, ST_EM_INT, ST_EM_SPAN, ST_EM_OUT
   } state_type;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] bstart;
      logic [POS_W-1:0]   blen;
      logic [COORD_W-1:0] intron;
      logic [COORD_W-1:0] span;
      logic               last;
   } rsp_type;

   localparam rsp_type RSP_INVALID = '{ok: 1'b0, bstart: '0, blen: '0, intron: '0,
                                       span: '0, last: 1'b1};

   cfg_type      cfg;
   alu_req_type  alu_req;
   alu_rsp_type  alu_rsp;

   state_type          state_ff;
   cnt_type            count_ff;
   logic               ovf_ff;
   idx_type            i_ff;
   logic [TXC_W-1:0]   pos_ff;
   logic [TXC_W-1:0]   cur_ff;
   logic [POS_W-1:0]   rem_ff;
   logic [COORD_W-1:0] elen_ff;
   logic [TXC_W-1:0]   off_ff;
   logic [COORD_W-1:0] avail_ff;
   logic [POS_W-1:0]   take_ff;
   logic [COORD_W-1:0] bs_ff;
   cnt_type            nblk_ff;
   cnt_type            k_ff;
   logic [COORD_W-1:0] end_ff;
   logic [COORD_W-1:0] tail_end_ff;
   logic [COORD_W-1:0] first_ff;
   logic [COORD_W-1:0] intron_ff;
   logic               rsp_valid_ff;
   rsp_type            out_ff;

   // Exon table and block buffer ports
   logic     ex_wr_en;
   idx_type  ex_wr_addr;
   exon_type ex_wr_data;
   logic     ex_rd_en;
   idx_type  ex_rd_addr;
   exon_type ex_rd;
   logic     bk_wr_en;
   idx_type  bk_wr_addr;
   blk_type  bk_wr_data;
   logic     bk_rd_en;
   idx_type  bk_rd_addr;
   blk_type  bk_rd;

   cnt_type  rev_idx;
   cnt_type  k_prev;
   logic     walk_last;
   logic     table_full;
   blk_type  new_blk;

   ttgp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ttgp_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   ttgp_ram #(.WIDTH($bits(exon_type)), .DEPTH(MAX_EXONS)) u_exon_ram (
      .clock   (clock),
      .wr_en   (ex_wr_en),
      .wr_addr (ex_wr_addr),
      .wr_data (ex_wr_data),
      .rd_en   (ex_rd_en),
      .rd_addr (ex_rd_addr),
      .rd_data (ex_rd)
   );

   ttgp_ram #(.WIDTH($bits(blk_type)), .DEPTH(MAX_EXONS)) u_blk_ram (
      .clock   (clock),
      .wr_en   (bk_wr_en),
      .wr_addr (bk_wr_addr),
      .wr_data (bk_wr_data),
      .rd_en   (bk_rd_en),
      .rd_addr (bk_rd_addr),
      .rd_data (bk_rd)
   );

   // Walk bookkeeping
   assign rev_idx    = count_ff - cnt_type'(i_ff) - cnt_type'(1);
   assign k_prev     = k_ff - cnt_type'(1);
   assign walk_last  = (cnt_type'(i_ff) + cnt_type'(1)) == count_ff;
   assign table_full = count_ff >= cnt_type'(MAX_EXONS);
   assign new_blk    = '{bstart: bs_ff, blen: take_ff};

   // Shared adder operand select
   always_comb begin
      alu_req = '0;
      unique case (state_ff)
         ST_IDLE:    alu_req = '{sub: 1'b1, a: req_donor_site,
                                 b: COORD_W'(cfg.flank_length)};
         ST_JCT_RS:  alu_req = '{sub: 1'b1, a: bs_ff, b: COORD_W'(1)};
         ST_JCT_WR:  alu_req = '{sub: 1'b0, a: bs_ff, b: COORD_W'(cfg.flank_length)};
         ST_LEN:     alu_req = '{sub: 1'b1, a: ex_rd.ex_stop, b: ex_rd.ex_start};
         ST_OFF:     alu_req = '{sub: 1'b1, a: COORD_W'(pos_ff), b: COORD_W'(cur_ff)};
         ST_CMP:     alu_req = '{sub: 1'b1, a: COORD_W'(off_ff), b: elen_ff};
         ST_SKIP:    alu_req = '{sub: 1'b0, a: COORD_W'(cur_ff), b: elen_ff};
         ST_AVL:     alu_req = '{sub: 1'b1, a: elen_ff, b: COORD_W'(off_ff)};
         ST_TAKE:    alu_req = '{sub: 1'b1, a: COORD_W'(rem_ff), b: avail_ff};
         ST_BS1: begin
            if (cfg.strand_minus) begin
               alu_req = '{sub: 1'b1, a: ex_rd.ex_stop, b: COORD_W'(off_ff)};
            end else begin
               alu_req = '{sub: 1'b0, a: ex_rd.ex_start, b: COORD_W'(off_ff)};
            end
         end
         ST_BS2:     alu_req = '{sub: 1'b1, a: bs_ff, b: COORD_W'(take_ff)};
         ST_REM:     alu_req = '{sub: 1'b1, a: COORD_W'(rem_ff), b: COORD_W'(take_ff)};
         ST_POS:     alu_req = '{sub: 1'b0, a: COORD_W'(pos_ff), b: COORD_W'(take_ff)};
         ST_INS_CMP: alu_req = '{sub: 1'b1, a: bs_ff, b: bk_rd.bstart};
         ST_EM_END:  alu_req = '{sub: 1'b0, a: bk_rd.bstart, b: COORD_W'(bk_rd.blen)};
         ST_EM_INT:  alu_req = '{sub: 1'b1, a: bk_rd.bstart, b: tail_end_ff};
         ST_EM_SPAN: alu_req = '{sub: 1'b1, a: end_ff, b: first_ff};
         default:    alu_req = '0;
      endcase
   end

   // Memory port control
   always_comb begin
      ex_wr_en   = 1'b0;
      ex_wr_addr = '0;
      ex_wr_data = '{ex_start: req_exon_start, ex_stop: req_exon_end};
      ex_rd_en   = (state_ff == ST_RD);
      ex_rd_addr = cfg.strand_minus ? rev_idx[IDX_W-1:0] : i_ff;
      bk_wr_en   = 1'b0;
      bk_wr_addr = k_ff[IDX_W-1:0];
      bk_wr_data = new_blk;
      bk_rd_en   = 1'b0;
      bk_rd_addr = k_prev[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_type == REQ_APPEND && !table_full) begin
               ex_wr_en   = 1'b1;
               ex_wr_addr = count_ff[IDX_W-1:0];
            end else if (req_valid && req_type == REQ_JUNCTION) begin
               ex_wr_en   = 1'b1;
               ex_wr_addr = '0;
               ex_wr_data = '{ex_start: alu_rsp.res, ex_stop: req_donor_site};
            end
         end
         ST_JCT_WR: begin
            ex_wr_en   = 1'b1;
            ex_wr_addr = idx_type'(1);
            ex_wr_data = '{ex_start: bs_ff, ex_stop: alu_rsp.res};
         end
         ST_INS: begin
            if (k_ff == '0) begin
               bk_wr_en = 1'b1;
            end else begin
               bk_rd_en = 1'b1;
            end
         end
         ST_INS_CMP: begin
            bk_wr_en = 1'b1;
            if (!alu_rsp.ge) begin
               // Shift the larger entry up, fetch the next one down
               bk_wr_data = bk_rd;
               bk_rd_en   = (k_prev != '0);
               bk_rd_addr = k_prev[IDX_W-1:0] - idx_type'(1);
            end
         end
         ST_INS_WR: begin
            bk_wr_en   = 1'b1;
            bk_wr_addr = '0;
         end
         ST_EM_RD: begin
            bk_rd_en   = 1'b1;
            bk_rd_addr = k_ff[IDX_W-1:0];
         end
         default: ;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  unique case (req_type)
                     REQ_CLEAR: begin
                        count_ff <= '0;
                        ovf_ff   <= 1'b0;
                     end
                     REQ_APPEND: begin
                        if (table_full) begin
                           ovf_ff <= 1'b1;
                        end else begin
                           count_ff <= count_ff + cnt_type'(1);
                        end
                     end
                     REQ_JUNCTION: begin
                        count_ff <= cnt_type'(2);
                        ovf_ff   <= 1'b0;
                        bs_ff    <= req_acceptor_site;
                        state_ff <= ST_JCT_RS;
                     end
                     REQ_QUERY: begin
                        pos_ff  <= TXC_W'(req_tx_pos);
                        cur_ff  <= '0;
                        rem_ff  <= req_align_len;
                        i_ff    <= '0;
                        nblk_ff <= '0;
                        if (req_align_len == '0 || count_ff == '0 || ovf_ff) begin
                           out_ff       <= RSP_INVALID;
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= ST_EM_OUT;
                        end else begin
                           state_ff <= ST_RD;
                        end
                     end
                  endcase
               end
            end
            ST_JCT_RS: begin
               bs_ff    <= alu_rsp.res;
               state_ff <= ST_JCT_WR;
            end
            ST_JCT_WR: state_ff <= ST_IDLE;
            ST_RD:     state_ff <= ST_LEN;
            ST_LEN: begin
               elen_ff  <= alu_rsp.res;
               state_ff <= ST_OFF;
            end
            ST_OFF: begin
               off_ff   <= alu_rsp.res[TXC_W-1:0];
               state_ff <= ST_CMP;
            end
            ST_CMP: state_ff <= alu_rsp.ge ? ST_SKIP : ST_AVL;
            ST_SKIP: begin
               // Exon lies wholly before the query start
               cur_ff <= alu_rsp.res[TXC_W-1:0];
               if (!walk_last) begin
                  i_ff     <= i_ff + idx_type'(1);
                  state_ff <= ST_RD;
               end else if (nblk_ff == '0) begin
                  out_ff       <= RSP_INVALID;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_EM_OUT;
               end else begin
                  k_ff     <= '0;
                  state_ff <= ST_EM_RD;
               end
            end
            ST_AVL: begin
               avail_ff <= alu_rsp.res;
               state_ff <= ST_TAKE;
            end
            ST_TAKE: begin
               take_ff  <= alu_rsp.ge ? avail_ff[POS_W-1:0] : rem_ff;
               state_ff <= ST_BS1;
            end
            ST_BS1: begin
               bs_ff    <= alu_rsp.res;
               state_ff <= cfg.strand_minus ? ST_BS2 : ST_REM;
            end
            ST_BS2: begin
               bs_ff    <= alu_rsp.res;
               state_ff <= ST_REM;
            end
            ST_REM: begin
               rem_ff   <= alu_rsp.res[POS_W-1:0];
               state_ff <= ST_POS;
            end
            ST_POS: begin
               pos_ff   <= alu_rsp.res[TXC_W-1:0];
               cur_ff   <= alu_rsp.res[TXC_W-1:0];
               k_ff     <= nblk_ff;
               state_ff <= ST_INS;
            end
            ST_INS, ST_INS_CMP, ST_INS_WR: begin
               if ((state_ff == ST_INS && k_ff == '0) ||
                   (state_ff == ST_INS_CMP && alu_rsp.ge) ||
                   state_ff == ST_INS_WR) begin
                  // Block placed: advance the walk or start emitting
                  nblk_ff <= nblk_ff + cnt_type'(1);
                  if (rem_ff == '0 || walk_last) begin
                     k_ff     <= '0;
                     state_ff <= ST_EM_RD;
                  end else begin
                     i_ff     <= i_ff + idx_type'(1);
                     state_ff <= ST_RD;
                  end
               end else if (state_ff == ST_INS) begin
                  state_ff <= ST_INS_CMP;
               end else begin
                  k_ff     <= k_prev;
                  state_ff <= (k_prev == '0) ? ST_INS_WR : ST_INS_CMP;
               end
            end
            ST_EM_RD: state_ff <= ST_EM_END;
            ST_EM_END: begin
               end_ff <= alu_rsp.res;
               if (k_ff == '0) begin
                  first_ff <= bk_rd.bstart;
               end
               state_ff <= ST_EM_INT;
            end
            ST_EM_INT: begin
               intron_ff <= (k_ff == '0) ? '0 : alu_rsp.res;
               state_ff  <= ST_EM_SPAN;
            end
            ST_EM_SPAN: begin
               out_ff       <= '{ok: 1'b1, bstart: bk_rd.bstart, blen: bk_rd.blen,
                                 intron: intron_ff, span: alu_rsp.res,
                                 last: (k_ff + cnt_type'(1)) == nblk_ff};
               tail_end_ff  <= end_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_EM_OUT;
            end
            ST_EM_OUT: begin
               // Hold the beat until the receiver takes it
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (out_ff.last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + cnt_type'(1);
                     state_ff <= ST_EM_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_valid  = out_ff.ok;
   assign rsp_block_start   = out_ff.bstart;
   assign rsp_block_length  = out_ff.blen;
   assign rsp_intron_length = out_ff.intron;
   assign rsp_span_so_far   = out_ff.span;
   assign rsp_last_block    = out_ff.last;

`ifndef SYNTHESIS
   a_no_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result beat pending while request side is open");

   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_valid) |-> rsp_last_block)
      else $error("failed query beat not marked last");

   a_block_bounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_valid) |->
         (nblk_ff != '0) && (nblk_ff <= count_ff) && (k_ff < nblk_ff))
      else $error("emitted block index outside the filled buffer");

   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_block) |=> !req_stall)
      else $error("request side not reopened after final beat");
`endif

endmodule

[verif/transcript_to_genome_projection_tb.sv]
`timescale 1ns / 1ps
module transcript_to_genome_projection_tb;
   import ttgp_pkg::*;

   localparam int RANDOM_ITEMS = 24;
   localparam int IDLE_PCT     = 28;
   localparam int SETTLE       = 20;
   localparam int TAIL         = 50;
   localparam int HOLD_CYCLES  = 600;
   localparam int STALL_LIMIT  = 40000;

   localparam logic [CSR_ADDR_W-1:0] ADDR_STRAND = {REG_STRAND_MINUS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_FLANK  = {REG_FLANK_LENGTH, 2'b00};

   typedef struct {
      req_code_type       kind;
      logic [COORD_W-1:0] exon_start;
      logic [COORD_W-1:0] exon_end;
      logic [COORD_W-1:0] donor_site;
      logic [COORD_W-1:0] acceptor_site;
      logic [POS_W-1:0]   tx_pos;
      logic [POS_W-1:0]   align_len;
   } exon_request_type;

   typedef struct {
      logic               ok;
      logic [COORD_W-1:0] bstart;
      logic [POS_W-1:0]   blen;
      logic [COORD_W-1:0] intron;
      logic [COORD_W-1:0] span;
      logic               last;
   } genome_block_type;

   // Mirror of the exon table; projects each query into expected blocks
   class projection_scoreboard;
      localparam int PRINT_LIMIT = 40;

      logic               strand_minus;
      logic [POS_W-1:0]   flank_length;
      logic [COORD_W-1:0] exon_lo [MAX_EXONS];
      logic [COORD_W-1:0] exon_hi [MAX_EXONS];
      int                 exon_count;
      logic               overflow;
      genome_block_type   expected_blocks [$];
      int                 mismatches;
      int                 requests;
      int                 queries;
      int                 blocks_checked;

      function new();
         strand_minus   = 1'b0;
         flank_length   = '0;
         exon_count     = 0;
         overflow       = 1'b0;
         mismatches     = 0;
         requests       = 0;
         queries        = 0;
         blocks_checked = 0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("%0t ns  mismatch: %s", $time, what);
      endtask

      function void push_invalid();
         genome_block_type b;
         b = '{default: '0};
         b.last = 1'b1;
         expected_blocks = {expected_blocks, b};
      endfunction

      function void project_query(logic [POS_W-1:0] tx_pos, logic [POS_W-1:0] align_len);
         longint unsigned    pos, left, walked, elen, off, avail, take;
         logic [COORD_W-1:0] lo, hi, bs, ext, span, tail_end, intron;
         logic [COORD_W-1:0] blk_start [MAX_EXONS];
         logic [POS_W-1:0]   blk_len [MAX_EXONS];
         int                 idx, nblk, k;
         genome_block_type   b;
         pos    = tx_pos;
         left   = align_len;
         walked = 0;
         nblk   = 0;
         if (left == 0 || exon_count == 0 || overflow) begin
            push_invalid();
            return;
         end
         // walk in transcript order, cutting out the covered part of each exon
         for (int i = 0; i < exon_count && left > 0; i++) begin
            idx  = strand_minus ? exon_count - 1 - i : i;
            lo   = exon_lo[idx];
            hi   = exon_hi[idx];
            ext  = hi - lo;
            elen = ext;
            if (pos >= walked + elen) begin
               walked += elen;
               continue;
            end
            off   = (pos > walked) ? pos - walked : 0;
            avail = elen - off;
            take  = (left < avail) ? left : avail;
            bs    = strand_minus ? hi - 32'(off) - 32'(take) : lo + 32'(off);
            // stable insert by genomic start; equal starts keep walk order
            k = nblk;
            while (k > 0 && blk_start[k-1] > bs) begin
               blk_start[k] = blk_start[k-1];
               blk_len[k]   = blk_len[k-1];
               k--;
            end
            blk_start[k] = bs;
            blk_len[k]   = 24'(take);
            nblk++;
            left   -= take;
            pos    += take;
            walked += elen;
         end
         if (nblk == 0) begin
            push_invalid();
            return;
         end
         // emit in genomic order with intron and running span
         span     = '0;
         tail_end = '0;
         for (int j = 0; j < nblk; j++) begin
            intron   = (j == 0) ? '0 : blk_start[j] - tail_end;
            span     = span + intron + blk_len[j];
            b.ok     = 1'b1;
            b.bstart = blk_start[j];
            b.blen   = blk_len[j];
            b.intron = intron;
            b.span   = span;
            b.last   = (j == nblk - 1);
            expected_blocks = {expected_blocks, b};
            tail_end = blk_start[j] + blk_len[j];
         end
      endfunction

      function void note_request(exon_request_type r);
         logic [COORD_W-1:0] rs;
         requests++;
         case (r.kind)
            REQ_CLEAR: begin
               exon_count = 0;
               overflow   = 1'b0;
            end
            REQ_APPEND: begin
               if (exon_count < MAX_EXONS) begin
                  exon_lo[exon_count] = r.exon_start;
                  exon_hi[exon_count] = r.exon_end;
                  exon_count++;
               end else begin
                  overflow = 1'b1;
               end
            end
            REQ_JUNCTION: begin
               rs         = r.acceptor_site - 1;
               exon_lo[0] = r.donor_site - flank_length;
               exon_hi[0] = r.donor_site;
               exon_lo[1] = rs;
               exon_hi[1] = rs + flank_length;
               exon_count = 2;
               overflow   = 1'b0;
            end
            REQ_QUERY: begin
               queries++;
               project_query(r.tx_pos, r.align_len);
            end
         endcase
      endfunction

      task check_result(genome_block_type got);
         genome_block_type want;
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, start %h",
                                      got.bstart));
            return;
         end
         want = expected_blocks.pop_front();
         blocks_checked++;
         if (got.ok !== want.ok)
            report_mismatch($sformatf("result_valid %b, want %b", got.ok, want.ok));
         if (got.bstart !== want.bstart)
            report_mismatch($sformatf("block_start %h, want %h", got.bstart, want.bstart));
         if (got.blen !== want.blen)
            report_mismatch($sformatf("block_length %h, want %h", got.blen, want.blen));
         if (got.intron !== want.intron)
            report_mismatch($sformatf("intron_length %h, want %h", got.intron, want.intron));
         if (got.span !== want.span)
            report_mismatch($sformatf("span_so_far %h, want %h", got.span, want.span));
         if (got.last !== want.last)
            report_mismatch($sformatf("last_block %b, want %b", got.last, want.last));
      endtask

      task finish_check();
         if (expected_blocks.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived",
                                      expected_blocks.size()));
      endtask
   endclass

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type          = 2'b00;
   logic [COORD_W-1:0]    req_exon_start    = '0;
   logic [COORD_W-1:0]    req_exon_end      = '0;
   logic [COORD_W-1:0]    req_donor_site    = '0;
   logic [COORD_W-1:0]    req_acceptor_site = '0;
   logic [POS_W-1:0]      req_tx_pos        = '0;
   logic [POS_W-1:0]      req_align_len     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic                  rsp_result_valid;
   logic [COORD_W-1:0]    rsp_block_start;
   logic [POS_W-1:0]      rsp_block_length;
   logic [COORD_W-1:0]    rsp_intron_length;
   logic [COORD_W-1:0]    rsp_span_so_far;
   logic                  rsp_last_block;
   logic                  psel              = 1'b0;
   logic                  penable           = 1'b0;
   logic                  pwrite            = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr             = '0;
   logic [CSR_DATA_W-1:0] pwdata            = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   projection_scoreboard sb = new();

   bit sender_idling = 1'b1;
   bit rsp_idling    = 1'b1;
   bit hold_request  = 1'b0;
   int beats_moved   = 0;
   int items_sent    = 0;
   int csr_writes    = 0;

   transcript_to_genome_projection u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_exon_start    (req_exon_start),
      .req_exon_end      (req_exon_end),
      .req_donor_site    (req_donor_site),
      .req_acceptor_site (req_acceptor_site),
      .req_tx_pos        (req_tx_pos),
      .req_align_len     (req_align_len),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_valid  (rsp_result_valid),
      .rsp_block_start   (rsp_block_start),
      .rsp_block_length  (rsp_block_length),
      .rsp_intron_length (rsp_intron_length),
      .rsp_span_so_far   (rsp_span_so_far),
      .rsp_last_block    (rsp_last_block),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall, or a long hold-off when asked for
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rsp_idling && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // take each result beat and check it against the oldest pending block
   always @(posedge clock) begin : result_monitor
      genome_block_type beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         beat.ok     = rsp_result_valid;
         beat.bstart = rsp_block_start;
         beat.blen   = rsp_block_length;
         beat.intron = rsp_intron_length;
         beat.span   = rsp_span_so_far;
         beat.last   = rsp_last_block;
         sb.check_result(beat);
         beats_moved++;
      end
   end

   // end the run when no beat moves for too long
   initial begin : watchdog
      int quiet_cycles, seen;
      quiet_cycles = 0;
      seen         = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (beats_moved != seen) begin
            seen         = beats_moved;
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // offer one request beat after an optional gap, hold it until taken
   task automatic send_beat(exon_request_type r);
      int gap;
      gap = 0;
      while (sender_idling && $urandom_range(0, 99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= r.kind;
      req_exon_start    <= r.exon_start;
      req_exon_end      <= r.exon_end;
      req_donor_site    <= r.donor_site;
      req_acceptor_site <= r.acceptor_site;
      req_tx_pos        <= r.tx_pos;
      req_align_len     <= r.align_len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      beats_moved++;
      items_sent++;
   endtask

   // drop valid, wait for every pending block, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_ADDR_W-1:0] addr,
                                 logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_STRAND) sb.strand_minus = data[0];
      else sb.flank_length = data[POS_W-1:0];
      csr_writes++;
   endtask

   // unused fields carry random bits so every input bit toggles
   function automatic exon_request_type any_request(req_code_type kind);
      exon_request_type r;
      r.kind          = kind;
      r.exon_start    = $urandom();
      r.exon_end      = $urandom();
      r.donor_site    = $urandom();
      r.acceptor_site = $urandom_range(1, 32'hFFFF_FFFF);
      r.tx_pos        = 24'($urandom());
      r.align_len     = 24'($urandom());
      return r;
   endfunction

   task automatic send_clear();
      send_beat(any_request(REQ_CLEAR));
   endtask

   task automatic send_append(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi);
      exon_request_type r;
      r            = any_request(REQ_APPEND);
      r.exon_start = lo;
      r.exon_end   = hi;
      send_beat(r);
   endtask

   task automatic send_junction(logic [COORD_W-1:0] donor, logic [COORD_W-1:0] acceptor);
      exon_request_type r;
      r               = any_request(REQ_JUNCTION);
      r.donor_site    = donor;
      r.acceptor_site = acceptor;
      send_beat(r);
   endtask

   task automatic send_query(logic [POS_W-1:0] pos, logic [POS_W-1:0] len);
      exon_request_type r;
      r           = any_request(REQ_QUERY);
      r.tx_pos    = pos;
      r.align_len = len;
      send_beat(r);
   endtask

   // load a well-formed table: a junction or a run of ascending exons
   task automatic build_table(output longint unsigned total);
      int                 n, len;
      logic [COORD_W-1:0] cursor, lo;
      total = 0;
      if ($urandom_range(0, 99) < 20) begin
         send_junction($urandom(), $urandom_range(1, 32'hFFFF_FFFF));
         total = 2 * sb.flank_length;
      end else begin
         send_clear();
         n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 24);
         cursor = $urandom_range(0, 32'hF000_0000);
         repeat (n) begin
            lo  = cursor + $urandom_range(0, 400);
            len = $urandom_range(0, 200);
            send_append(lo, lo + len);
            cursor = lo + len;
            total += len;
         end
      end
   endtask

   task automatic send_random_query(longint unsigned total);
      int unsigned      top, pick;
      logic [POS_W-1:0] pos, len;
      top  = (total > 64'hFF_FFFF) ? 32'hFF_FFFF : 32'(total);
      pos  = 24'($urandom_range(0, top));
      pick = $urandom_range(0, 99);
      if (pick < 60) len = 24'($urandom_range(1, 500));
      else if (pick < 80) len = 24'($urandom_range(1, top + 1));
      else if (pick < 88) len = '0;
      else len = 24'($urandom());
      send_query(pos, len);
   endtask

   // raw beats of any kind, wrapped exons and all
   task automatic send_noise();
      exon_request_type r;
      repeat ($urandom_range(3, 6)) begin
         r = any_request(req_code_type'($urandom_range(0, 3)));
         if ($urandom_range(0, 1)) begin
            r.tx_pos    = 24'($urandom_range(0, 300));
            r.align_len = 24'($urandom_range(0, 300));
         end
         send_beat(r);
      end
   endtask

   task automatic shuffle_config();
      drain();
      write_register(ADDR_STRAND, $urandom_range(0, 1));
      write_register(ADDR_FLANK, ($urandom_range(0, 99) < 80) ? $urandom_range(0, 300)
                                                              : $urandom() & 32'hFF_FFFF);
   endtask

   initial begin : stimulus
      longint unsigned total;
      int              start;
      bit              quiet;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full-scale flank, plus strand; query the empty table first
      write_register(ADDR_STRAND, 32'd0);
      write_register(ADDR_FLANK, 32'hFF_FFFF);
      send_query(24'd0, 24'd10);
      // junction whose flanks wrap around zero
      send_junction(32'h10, 32'hFFFF_FFF0);
      send_query(24'hFF_FFF0, 24'd40);

      // plain ascending table: spanning, zero length, no overlap, maximal read
      send_clear();
      send_append(32'd100, 32'd200);
      send_append(32'd300, 32'd350);
      send_append(32'd1000, 32'd1100);
      send_query(24'd50, 24'd120);
      send_query(24'd0, 24'd0);
      send_query(24'hFF_FFFF, 24'hFF_FFFF);
      send_query(24'd0, 24'hFF_FFFF);
      // zero-length exon, then one that wraps past the top of the genome
      send_append(32'd2000, 32'd2000);
      send_append(32'hFFFF_FFF0, 32'h10);
      send_query(24'd240, 24'd40);

      // minus strand: reversed walk and reordered blocks
      drain();
      write_register(ADDR_STRAND, 32'd1);
      send_query(24'd10, 24'd300);
      // equal starts, and an exon with end below start
      send_clear();
      send_append(32'd100, 32'd110);
      send_append(32'd100, 32'd120);
      send_query(24'd0, 24'd30);
      send_append(32'd500, 32'd100);
      send_query(24'd25, 24'd60);
      drain();
      write_register(ADDR_STRAND, 32'd0);
      send_query(24'd0, 24'd30);

      // zero flank makes both junction exons empty
      drain();
      write_register(ADDR_FLANK, 32'd0);
      send_junction(32'd5000, 32'd6001);
      send_query(24'd0, 24'd5);

      // fill the table, project across all of it, then overflow it
      drain();
      write_register(ADDR_FLANK, 32'd20);
      write_register(ADDR_STRAND, 32'd1);
      send_clear();
      for (int i = 0; i < MAX_EXONS; i++)
         send_append(i * 1000 + 7, i * 1000 + 107 + i);
      send_query(24'd0, 24'hFF_FFFF);
      send_append(32'd99999, 32'd100050);
      send_query(24'd0, 24'd10);
      drain();
      write_register(ADDR_STRAND, 32'd0);
      send_query(24'd5, 24'hFF_FFFF);
      send_junction(32'd300, 32'd401);

      // hold the result side off while queries keep coming
      hold_request = 1'b1;
      send_query(24'd3, 24'd30);
      send_query(24'd0, 24'd40);
      send_query(24'd19, 24'd2);
      send_query(24'd10, 24'd25);
      drain();

      // random phase: mostly well-formed tables with queries, some noise
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         quiet         = (items_sent - start >= 4) && (items_sent - start < 16);
         sender_idling = !quiet;
         rsp_idling    = !quiet;
         if ($urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 3) == 0) shuffle_config();
            build_table(total);
            repeat ($urandom_range(2, 4)) send_random_query(total);
         end else begin
            send_noise();
         end
      end
      sender_idling = 1'b1;
      rsp_idling    = 1'b1;

      drain();
      repeat (TAIL) @(posedge clock);
      sb.finish_check();
      $display("covered %0d request beats (%0d queries) and %0d result beats",
               sb.requests, sb.queries, sb.blocks_checked);
      $display("both strands, flank 0 to full scale over %0d register writes, %s",
               csr_writes, "a full and overflowed table, and a long result hold-off");
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[transcript_to_genome_projection.f]
hdl/ttgp_pkg.sv
hdl/ttgp_ram.sv
hdl/ttgp_alu.sv
hdl/ttgp_csr.sv
hdl/transcript_to_genome_projection.sv
verif/transcript_to_genome_projection_tb.sv
